>>> rtl/spg_pkg.sv
// ----------------------------------------------------------------------------
// spg_pkg
// Shared types, register indexes and constants for the stepper step-pulse
// generator with sensor pause.
// ----------------------------------------------------------------------------
package spg_pkg;

  localparam int unsigned DefTickCountWidth = 16;
  localparam int unsigned CfgWidth          = 16;
  localparam int unsigned CfgIdxWidth       = 3;
  localparam int unsigned MsWidth           = 3;
  localparam int unsigned ResCodeWidth      = 3;

  localparam logic [CfgWidth-1:0]     StopTicksReset = 16'd1000;
  localparam logic [CfgWidth-1:0]     StepsReset     = 16'd10;
  localparam logic [ResCodeWidth-1:0] ResCodeMax     = 3'd4;

  typedef enum logic [1:0] {
    ModeWatch  = 2'd0,
    ModeBurst  = 2'd1,
    ModeDwell  = 2'd2,
    ModeFollow = 2'd3
  } seq_mode_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    RegHalfPeriod  = 3'd0,
    RegStopTicks   = 3'd1,
    RegStepsToTake = 3'd2,
    RegPauseEnable = 3'd3,
    RegResolution  = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic [CfgWidth-1:0] half_period;
    logic [CfgWidth-1:0] stop_ticks;
    logic [CfgWidth-1:0] steps_to_take;
    logic                pause_en;
  } spg_cfg_t;

  typedef struct packed {
    logic      step_level;
    logic      edge_event;
    seq_mode_e seq_phase;
  } spg_res_t;

  // microstep pin pattern for a resolution code (log2 of microsteps)
  function automatic logic [MsWidth-1:0] ms_pins_for(input logic [ResCodeWidth-1:0] code);
    logic [MsWidth-1:0] pins;
    unique case (code)
      3'd0:    pins = 3'b000;
      3'd1:    pins = 3'b001;
      3'd2:    pins = 3'b010;
      3'd3:    pins = 3'b011;
      3'd4:    pins = 3'b111;
      default: pins = 3'b000;
    endcase
    return pins;
  endfunction

endpackage

>>> rtl/stepper_pulse_gen_sensor_pause.sv
// ----------------------------------------------------------------------------
// stepper_pulse_gen_sensor_pause
// Step-pulse generator driven by tick items, with sensor-triggered burst,
// dwell step and sensor following.
// ----------------------------------------------------------------------------
// One input transfer is one tick with the sensor level; one output transfer
// carries the step pin level, active-low driver enable, microstep pins, burst
// edge flag and sequencer phase after that tick. The block takes one tick per
// clock while the output is not stalled: a tick passes an input register, the
// phase and sequencer update in combinational logic, and the result lands in
// an output register; the output register lets a new tick in while a result
// waits. Configuration writes are taken at any time (cfg_ready_o is always
// high) and must only happen while no tick is in flight.
module stepper_pulse_gen_sensor_pause #(
  parameter int unsigned TickCountWidth = spg_pkg::DefTickCountWidth
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [spg_pkg::CfgIdxWidth-1:0] cfg_index_i,
  input  logic [spg_pkg::CfgWidth-1:0]    cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic                            sensor_level_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            step_level_o,
  output logic                            enable_n_o,
  output logic [spg_pkg::MsWidth-1:0]     ms_pins_o,
  output logic                            edge_event_o,
  output logic [1:0]                      seq_phase_o
);

  spg_pkg::spg_cfg_t             cfg_q, cfg_d;
  logic                          drv_en_q, drv_en_d;
  logic [spg_pkg::MsWidth-1:0]   ms_held_q, ms_held_d;

  logic                          s1_valid_q, s1_valid_d;
  logic                          s1_sensor_q;
  logic                          out_valid_q, out_valid_d;
  logic                          out_adv, s1_adv, in_fire, cfg_fire;
  spg_pkg::spg_res_t             core_res;
  spg_pkg::spg_res_t             res_q;
  logic                          enable_n_q;
  logic [spg_pkg::MsWidth-1:0]   ms_pins_q;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i;

  always_comb begin
    cfg_d     = cfg_q;
    drv_en_d  = drv_en_q;
    ms_held_d = ms_held_q;
    if (cfg_fire) begin
      unique case (cfg_index_i)
        spg_pkg::RegHalfPeriod: begin
          cfg_d.half_period = cfg_data_i;
          if (cfg_data_i != '0) begin
            drv_en_d = 1'b1;
          end
        end
        spg_pkg::RegStopTicks:   cfg_d.stop_ticks    = cfg_data_i;
        spg_pkg::RegStepsToTake: cfg_d.steps_to_take = cfg_data_i;
        spg_pkg::RegPauseEnable: cfg_d.pause_en      = cfg_data_i[0];
        spg_pkg::RegResolution: begin
          // out-of-range codes keep the current pins
          if (cfg_data_i[spg_pkg::ResCodeWidth-1:0] <= spg_pkg::ResCodeMax) begin
            ms_held_d = spg_pkg::ms_pins_for(cfg_data_i[spg_pkg::ResCodeWidth-1:0]);
          end
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.half_period   <= '0;
      cfg_q.stop_ticks    <= spg_pkg::StopTicksReset;
      cfg_q.steps_to_take <= spg_pkg::StepsReset;
      cfg_q.pause_en      <= 1'b0;
      drv_en_q            <= 1'b0;
      ms_held_q           <= '0;
    end else begin
      cfg_q     <= cfg_d;
      drv_en_q  <= drv_en_d;
      ms_held_q <= ms_held_d;
    end
  end

  // two-stage flow: input register, then result register
  assign out_adv    = !out_valid_q || out_ready_i;
  assign s1_adv     = s1_valid_q && out_adv;
  assign in_ready_o = !s1_valid_q || out_adv;
  assign in_fire    = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_fire) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_sensor_q <= sensor_level_i;
    end
    if (s1_adv) begin
      res_q      <= core_res;
      enable_n_q <= ~drv_en_q;
      ms_pins_q  <= ms_held_q;
    end
  end

  spg_core #(
    .TickCountWidth(TickCountWidth)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (s1_adv),
    .sensor_i(s1_sensor_q),
    .cfg_i   (cfg_q),
    .res_o   (core_res)
  );

  assign out_valid_o  = out_valid_q;
  assign step_level_o = res_q.step_level;
  assign edge_event_o = res_q.edge_event;
  assign seq_phase_o  = res_q.seq_phase;
  assign enable_n_o   = enable_n_q;
  assign ms_pins_o    = ms_pins_q;

  // a burst can only start in pause mode
  a_edge_needs_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_adv && core_res.edge_event |-> cfg_q.pause_en)
    else $error("burst edge outside pause mode");

  // a burst edge always leaves the sequencer in burst or dwell
  a_edge_phase: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && edge_event_o |->
      (seq_phase_o == spg_pkg::ModeBurst) || (seq_phase_o == spg_pkg::ModeDwell))
    else $error("edge event with wrong phase");

  // the driver stays enabled once enabled
  a_drv_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    drv_en_q |=> drv_en_q)
    else $error("driver enable dropped");

  // a tick held in the input register is not lost while the output stalls
  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !out_adv |=> s1_valid_q && $stable(s1_sensor_q))
    else $error("input register lost a tick");

endmodule

>>> rtl/spg_core.sv
// ----------------------------------------------------------------------------
// spg_core
// Phase counter, step pin level and sensor pause sequencer. Advances one tick
// per adv_i and presents the result of that tick combinationally.
// ----------------------------------------------------------------------------
module spg_core #(
  parameter int unsigned TickCountWidth = spg_pkg::DefTickCountWidth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             adv_i,
  input  logic             sensor_i,
  input  spg_pkg::spg_cfg_t cfg_i,
  output spg_pkg::spg_res_t res_o
);

  localparam int unsigned CmpWidth =
    (TickCountWidth > spg_pkg::CfgWidth) ? TickCountWidth : spg_pkg::CfgWidth;

  spg_pkg::seq_mode_e              mode_q, mode_d;
  logic                            phase_high_q, phase_high_d;
  logic [TickCountWidth-1:0]       cnt_q, cnt_d;
  logic [spg_pkg::CfgWidth-1:0]    burst_q, burst_d;
  logic                            step_out_q, step_out_d;

  logic [TickCountWidth-1:0]       cnt_inc;
  logic [spg_pkg::CfgWidth-1:0]    len;
  logic [spg_pkg::CfgWidth-1:0]    burst_dec;
  logic                            hit;
  logic                            edge_d;

  always_comb begin
    mode_d       = mode_q;
    phase_high_d = phase_high_q;
    cnt_d        = cnt_q;
    burst_d      = burst_q;
    step_out_d   = step_out_q;
    edge_d       = 1'b0;

    // dwell step stretches only its low phase; zero length counts as one tick
    if (!phase_high_q && cfg_i.pause_en && (mode_q == spg_pkg::ModeDwell)) begin
      len = (cfg_i.stop_ticks != '0) ? cfg_i.stop_ticks : spg_pkg::CfgWidth'(1);
    end else begin
      len = cfg_i.half_period;
    end
    cnt_inc   = cnt_q + TickCountWidth'(1);
    hit       = CmpWidth'(cnt_inc) >= CmpWidth'(len);
    burst_dec = (burst_q != '0) ? burst_q - spg_pkg::CfgWidth'(1) : burst_q;

    if (cfg_i.half_period != '0) begin
      step_out_d = phase_high_q;
      cnt_d      = cnt_inc;
      if (hit) begin
        cnt_d        = '0;
        phase_high_d = ~phase_high_q;
        if (phase_high_q) begin
          // step completed: sample the sensor
          if (!cfg_i.pause_en) begin
            mode_d = spg_pkg::ModeFollow;
          end else begin
            unique case (mode_q)
              spg_pkg::ModeWatch: begin
                if (sensor_i) begin
                  edge_d  = 1'b1;
                  burst_d = cfg_i.steps_to_take;
                  mode_d  = (cfg_i.steps_to_take != '0) ? spg_pkg::ModeBurst
                                                        : spg_pkg::ModeDwell;
                end
              end
              spg_pkg::ModeBurst: begin
                burst_d = burst_dec;
                if (burst_dec == '0) begin
                  mode_d = spg_pkg::ModeDwell;
                end
              end
              spg_pkg::ModeDwell: begin
                mode_d = spg_pkg::ModeFollow;
              end
              spg_pkg::ModeFollow: begin
                if (!sensor_i) begin
                  mode_d = spg_pkg::ModeWatch;
                end
              end
              default: begin
                mode_d = mode_q;
              end
            endcase
          end
        end
      end
    end

    res_o.step_level = step_out_d;
    res_o.edge_event = edge_d;
    res_o.seq_phase  = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q       <= spg_pkg::ModeFollow;
      phase_high_q <= 1'b0;
      cnt_q        <= '0;
      burst_q      <= '0;
      step_out_q   <= 1'b0;
    end else if (adv_i) begin
      mode_q       <= mode_d;
      phase_high_q <= phase_high_d;
      cnt_q        <= cnt_d;
      burst_q      <= burst_d;
      step_out_q   <= step_out_d;
    end
  end

endmodule

>>> dv/stepper_pulse_gen_sensor_pause_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stepper_pulse_gen_sensor_pause_tb
// Self-checking bench for the step-pulse generator. Tick transfers carry
// random sensor levels. Configuration changes between phases, only while no
// tick is in flight. A tracker predicts the step pin, the enable, the
// microstep pins, the burst edge and the sequencer phase for each tick. Each
// result transfer is checked against the oldest prediction. Both sides stall
// at random. The receiver also holds off once for a long stretch.
// ----------------------------------------------------------------------------
module stepper_pulse_gen_sensor_pause_tb;

  localparam int unsigned CntWidth       = spg_pkg::DefTickCountWidth;
  localparam logic [spg_pkg::CfgIdxWidth-1:0] RegUnusedFirst = 3'd5;
  localparam logic [spg_pkg::CfgIdxWidth-1:0] RegUnusedMid   = 3'd6;
  localparam logic [spg_pkg::CfgIdxWidth-1:0] RegUnusedLast  = 3'd7;
  localparam int unsigned RandomTicks    = 700;
  localparam int unsigned CycleLimit     = 200000;
  localparam int unsigned HoldOffCycles  = 300;

  typedef struct packed {
    logic                        step_level;
    logic                        enable_n;
    logic [spg_pkg::MsWidth-1:0] ms_pins;
    logic                        edge_event;
    logic [1:0]                  seq_phase;
  } pin_state_t;

  // tracks the generator state and queues the pin states each tick yields
  class pulse_scoreboard;
    logic [spg_pkg::CfgWidth-1:0] half_period;
    logic [spg_pkg::CfgWidth-1:0] stop_len;
    logic [spg_pkg::CfgWidth-1:0] burst_len;
    bit                           pause_en;
    spg_pkg::seq_mode_e           mode;
    bit                           high_phase;
    logic [CntWidth-1:0]          phase_cnt;
    logic [spg_pkg::CfgWidth-1:0] burst_left;
    bit                           step_lvl;
    bit                           drv_en;
    logic [spg_pkg::MsWidth-1:0]  ms;
    pin_state_t                   pin_queue[$];
    int                           err_cnt;

    function new();
      half_period = '0;
      stop_len    = spg_pkg::StopTicksReset;
      burst_len   = spg_pkg::StepsReset;
      pause_en    = 1'b0;
      mode        = spg_pkg::ModeFollow;
      high_phase  = 1'b0;
      phase_cnt   = '0;
      burst_left  = '0;
      step_lvl    = 1'b0;
      drv_en      = 1'b0;
      ms          = '0;
      err_cnt     = 0;
    endfunction

    function void write_reg(logic [spg_pkg::CfgIdxWidth-1:0] idx,
                            logic [spg_pkg::CfgWidth-1:0] data);
      case (idx)
        spg_pkg::RegHalfPeriod: begin
          half_period = data;
          if (data != '0) drv_en = 1'b1;
        end
        spg_pkg::RegStopTicks:   stop_len  = data;
        spg_pkg::RegStepsToTake: burst_len = data;
        spg_pkg::RegPauseEnable: pause_en  = data[0];
        spg_pkg::RegResolution: begin
          // codes below the max map onto the pins as they are; max sets all three
          if (data[spg_pkg::ResCodeWidth-1:0] <= spg_pkg::ResCodeMax)
            ms = (data[spg_pkg::ResCodeWidth-1:0] == spg_pkg::ResCodeMax) ?
                 3'b111 : data[spg_pkg::MsWidth-1:0];
        end
        default: ;
      endcase
    endfunction

    function void take_tick(bit sensor);
      pin_state_t          p;
      logic [CntWidth-1:0] len;
      bit                  trig;
      trig = 1'b0;
      if (half_period != '0) begin
        len = half_period;
        if (!high_phase && pause_en && mode == spg_pkg::ModeDwell)
          len = (stop_len != '0) ? stop_len : CntWidth'(1);
        step_lvl  = high_phase;
        phase_cnt = phase_cnt + 1'b1;
        if (phase_cnt >= len) begin
          phase_cnt = '0;
          // end of a high phase completes a step; sensor sampled here
          if (high_phase) begin
            if (!pause_en) begin
              mode = spg_pkg::ModeFollow;
            end else begin
              case (mode)
                spg_pkg::ModeWatch: begin
                  if (sensor) begin
                    trig       = 1'b1;
                    burst_left = burst_len;
                    mode       = (burst_left != '0) ? spg_pkg::ModeBurst
                                                    : spg_pkg::ModeDwell;
                  end
                end
                spg_pkg::ModeBurst: begin
                  if (burst_left != '0) burst_left = burst_left - 1'b1;
                  if (burst_left == '0) mode = spg_pkg::ModeDwell;
                end
                spg_pkg::ModeDwell: mode = spg_pkg::ModeFollow;
                default:            if (!sensor) mode = spg_pkg::ModeWatch;
              endcase
            end
          end
          high_phase = !high_phase;
        end
      end
      p.step_level = step_lvl;
      p.enable_n   = !drv_en;
      p.ms_pins    = ms;
      p.edge_event = trig;
      p.seq_phase  = mode;
      pin_queue.push_back(p);
    endfunction

    function void check_pins(pin_state_t got);
      pin_state_t want;
      if (pin_queue.size() == 0) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display({"result transfer with nothing pending: ",
                    "step %0b en_n %0b ms %0h edge %0b phase %0d"},
                   got.step_level, got.enable_n, got.ms_pins, got.edge_event,
                   got.seq_phase);
        return;
      end
      want = pin_queue.pop_front();
      if (got.step_level !== want.step_level || got.enable_n !== want.enable_n ||
          got.ms_pins !== want.ms_pins || got.edge_event !== want.edge_event ||
          got.seq_phase !== want.seq_phase) begin
        err_cnt++;
        if (err_cnt <= 10)
          $display({"pin mismatch: exp step %0b en_n %0b ms %0h edge %0b phase %0d, ",
                    "got step %0b en_n %0b ms %0h edge %0b phase %0d"},
                   want.step_level, want.enable_n, want.ms_pins, want.edge_event,
                   want.seq_phase,
                   got.step_level, got.enable_n, got.ms_pins, got.edge_event,
                   got.seq_phase);
      end
    endfunction
  endclass

  logic                            clk_i = 1'b0;
  logic                            rst_ni;
  logic                            cfg_valid_i;
  logic                            cfg_ready_o;
  logic [spg_pkg::CfgIdxWidth-1:0] cfg_index_i;
  logic [spg_pkg::CfgWidth-1:0]    cfg_data_i;
  logic                            in_valid_i;
  logic                            in_ready_o;
  logic                            sensor_level_i;
  logic                            out_valid_o;
  logic                            out_ready_i;
  logic                            step_level_o;
  logic                            enable_n_o;
  logic [spg_pkg::MsWidth-1:0]     ms_pins_o;
  logic                            edge_event_o;
  logic [1:0]                      seq_phase_o;

  pulse_scoreboard tracker = new();
  int unsigned     snd_idle_pct = 35;
  int unsigned     rcv_idle_pct = 68;
  int unsigned     ticks_sent   = 0;
  int unsigned     cycle_cnt    = 0;
  int unsigned     hold_left    = 0;
  bit              hold_req     = 1'b0;

  stepper_pulse_gen_sensor_pause i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .sensor_level_i (sensor_level_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .step_level_o   (step_level_o),
    .enable_n_o     (enable_n_o),
    .ms_pins_o      (ms_pins_o),
    .edge_event_o   (edge_event_o),
    .seq_phase_o    (seq_phase_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req) begin
      hold_left = HoldOffCycles;
      hold_req  = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(0, 99) >= rcv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    pin_state_t got;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got.step_level = step_level_o;
      got.enable_n   = enable_n_o;
      got.ms_pins    = ms_pins_o;
      got.edge_event = edge_event_o;
      got.seq_phase  = seq_phase_o;
      tracker.check_pins(got);
    end
  end

  // valid stays up between back-to-back ticks; callers lower it
  task automatic send_tick(input bit lvl);
    while ($urandom_range(0, 99) < snd_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i     <= 1'b1;
    sensor_level_i <= lvl;
    do @(posedge clk_i); while (!in_ready_o);
    tracker.take_tick(lvl);
    ticks_sent++;
  endtask

  task automatic cfg_write(input logic [spg_pkg::CfgIdxWidth-1:0] idx,
                           input logic [spg_pkg::CfgWidth-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, data);
  endtask

  // drain all ticks in flight before touching the registers
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (tracker.pin_queue.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned n;
    int unsigned k;
    bit          lvl;
    logic [15:0] v;

    rst_ni         <= 1'b0;
    cfg_valid_i    <= 1'b0;
    cfg_index_i    <= '0;
    cfg_data_i     <= '0;
    in_valid_i     <= 1'b0;
    sensor_level_i <= 1'b0;
    out_ready_i    <= 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // generator stopped out of reset: pins frozen, driver disabled
    send_tick(1'b0);
    send_tick(1'b1);
    wait_idle();

    // invalid resolution is dropped; unused indexes do nothing
    cfg_write(spg_pkg::RegResolution, 16'd4);
    cfg_write(spg_pkg::RegResolution, 16'hFFFF);
    cfg_write(RegUnusedFirst, 16'hFFFF);
    cfg_write(RegUnusedMid, 16'h5A5A);
    cfg_write(RegUnusedLast, 16'hFFFF);
    cfg_write(spg_pkg::RegPauseEnable, 16'hFFFF);
    cfg_write(spg_pkg::RegStepsToTake, 16'd0);
    cfg_write(spg_pkg::RegStopTicks, 16'd0);
    cfg_write(spg_pkg::RegHalfPeriod, 16'd1);
    cfg_valid_i <= 1'b0;
    // zero burst goes straight to a one-tick dwell, then follow and rewatch
    foreach (v[i]) if (i < 12) send_tick(i inside {[2:7]});
    wait_idle();

    cfg_write(spg_pkg::RegHalfPeriod, 16'hFFFF);
    cfg_write(spg_pkg::RegStepsToTake, 16'hFFFF);
    cfg_write(spg_pkg::RegStopTicks, 16'hFFFF);
    cfg_valid_i <= 1'b0;
    repeat (3) send_tick(1'b1);
    wait_idle();
    // shrink the phase below the running count: phase ends on the next tick
    cfg_write(spg_pkg::RegHalfPeriod, 16'd1);
    cfg_valid_i <= 1'b0;
    repeat (3) send_tick(1'b1);
    wait_idle();
    cfg_write(spg_pkg::RegPauseEnable, 16'hFFFE);
    cfg_valid_i <= 1'b0;
    repeat (3) send_tick(1'b0);

    phase_no = 0;
    lvl      = 1'b0;
    while (ticks_sent < 23 + RandomTicks) begin
      wait_idle();
      if (ticks_sent >= 23 + 2 * RandomTicks / 3) begin
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
      end else if (ticks_sent >= 23 + RandomTicks / 3) begin
        snd_idle_pct = 68;
        rcv_idle_pct = 35;
      end

      if ($urandom_range(0, 1)) begin
        k = $urandom_range(0, 99);
        v = (k < 10) ? 16'd0 : (k < 14) ? 16'hFFFF : 16'($urandom_range(1, 4));
        cfg_write(spg_pkg::RegHalfPeriod, v);
      end
      if ($urandom_range(0, 1)) begin
        k = $urandom_range(0, 99);
        v = (k < 8) ? 16'd0 : (k < 12) ? 16'hFFFF : 16'($urandom_range(1, 6));
        cfg_write(spg_pkg::RegStopTicks, v);
      end
      if ($urandom_range(0, 1)) begin
        k = $urandom_range(0, 99);
        v = (k < 10) ? 16'd0 : (k < 13) ? 16'hFFFF : 16'($urandom_range(1, 5));
        cfg_write(spg_pkg::RegStepsToTake, v);
      end
      if ($urandom_range(0, 2) == 0) begin
        v    = 16'($urandom);
        v[0] = ($urandom_range(0, 99) < 80);
        cfg_write(spg_pkg::RegPauseEnable, v);
      end
      if ($urandom_range(0, 2) == 0) cfg_write(spg_pkg::RegResolution, 16'($urandom));
      if ($urandom_range(0, 9) == 0)
        cfg_write(RegUnusedFirst + 3'($urandom_range(0, 2)), 16'($urandom));
      cfg_valid_i <= 1'b0;

      if (phase_no == 4) hold_req = 1'b1;
      n = $urandom_range(20, 50);
      repeat (n) begin
        // sensor in runs so bursts, dwell and following all get reached
        if ($urandom_range(0, 5) == 0) lvl = !lvl;
        send_tick(lvl);
      end
      phase_no++;
    end

    in_valid_i <= 1'b0;
    while (tracker.pin_queue.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
